FILE: src/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg: shared types and constants of the line rasterizer
// Field widths, request kinds, register indexes and the pixel word.
// ----------------------------------------------------------------------------
package brl_pkg;

  // Fixed field widths
  localparam int COORD_W   = 16;
  localparam int LABEL_W   = 16;
  localparam int SCALE_W   = 5;
  localparam int PIX_W     = 12;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Mapped product: (p - origin) is 17 bits, scale is 6 bits zero-extended
  localparam int PROD_W = COORD_W + 1 + SCALE_W + 1;

  // Request kinds carried on the input tuser bit
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_ADV  = 1'b1
  } brl_req_t;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ORIGIN_X   = 2'd0,
    CFG_ORIGIN_Y   = 2'd1,
    CFG_GRID_SCALE = 2'd2
  } brl_cfg_idx_t;

  // One emitted pixel word
  typedef struct packed {
    logic               last_pixel;
    logic [LABEL_W-1:0] pix_label;
    logic [PIX_W-1:0]   pix_y;
    logic [PIX_W-1:0]   pix_x;
  } brl_pix_t;

  // Status of the stepping core
  typedef struct packed {
    logic busy;
    logic exec;
    logic exec_adv;
  } brl_stat_t;

endpackage

FILE: src/bresenham_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit: streaming Bresenham line rasterizer
// Maps endpoints to grid; emits one pixel word per advance of an active line.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_t*. tuser = 0 loads a line (endpoints and id in
//   tdata); tuser = 1 asks for the next pixel. A load gives no output word,
//   an advance while no line is active gives none either. Each advance of an
//   active line gives one output word with the pixel position and id; tlast
//   marks the final pixel, after which the line is done.
//   Configuration (origin, scale) is written on cfg_* while the unit is idle.
// Timing:
//   A word passes an input register, the grid-mapping register and the
//   stepping core's result register on its way to out_tvalid. One word is
//   taken per cycle while in_tready is high; a pixel step subtracts 2*dminor
//   from the error and adds 2*dmajor back when the result is negative.
// Reset and stall:
//   Reset (rst_n low, synchronous) empties the pipeline, drops any active
//   line and restores origin 0 and scale 1. When out_tready is low, the
//   pending pixel holds; loads still pass and the two pipeline registers
//   keep taking words until an advance meets the held result.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_unit #(
  parameter int GRID_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // x_start, y_start, x_end, y_end, line_id
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // pix_x, pix_y, pix_label
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [brl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [brl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import brl_pkg::*;

  // Configuration registers
  logic signed [COORD_W-1:0] origin_x_r;
  logic signed [COORD_W-1:0] origin_y_r;
  logic [SCALE_W-1:0]        scale_r;

  // Input register
  logic                a_valid_r;
  brl_req_t            a_type_r;
  logic [COORD_W-1:0]  a_xs_r, a_ys_r, a_xe_r, a_ye_r;
  logic [LABEL_W-1:0]  a_label_r;
  logic                a_ready;

  // Mapped register
  logic                b_valid_r;
  brl_req_t            b_type_r;
  logic [GRID_BITS-1:0] b_x1_r, b_y1_r, b_x2_r, b_y2_r;
  logic [LABEL_W-1:0]  b_label_r;
  logic                b_in_ready;
  logic                b_ready;

  logic [GRID_BITS-1:0] gx1, gy1, gx2, gy2;
  brl_pix_t            pix;
  brl_stat_t           stat;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      scale_r    <= SCALE_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ORIGIN_X:   origin_x_r <= cfg_wdata[COORD_W-1:0];
        CFG_ORIGIN_Y:   origin_y_r <= cfg_wdata[COORD_W-1:0];
        CFG_GRID_SCALE: scale_r    <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage flow control
  assign b_in_ready = !b_valid_r || b_ready;
  assign a_ready    = !a_valid_r || b_in_ready;
  assign in_tready  = a_ready;

  // Capture input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_tvalid) begin
      a_type_r  <= brl_req_t'(in_tuser);
      a_xs_r    <= in_tdata[15:0];
      a_ys_r    <= in_tdata[31:16];
      a_xe_r    <= in_tdata[47:32];
      a_ye_r    <= in_tdata[63:48];
      a_label_r <= in_tdata[79:64];
    end
  end

  // Map endpoints to the grid
  brl_map #(.GRID_BITS(GRID_BITS)) u_map_x1 (
    .coord(a_xs_r), .origin(origin_x_r), .scale(scale_r), .grid(gx1)
  );
  brl_map #(.GRID_BITS(GRID_BITS)) u_map_y1 (
    .coord(a_ys_r), .origin(origin_y_r), .scale(scale_r), .grid(gy1)
  );
  brl_map #(.GRID_BITS(GRID_BITS)) u_map_x2 (
    .coord(a_xe_r), .origin(origin_x_r), .scale(scale_r), .grid(gx2)
  );
  brl_map #(.GRID_BITS(GRID_BITS)) u_map_y2 (
    .coord(a_ye_r), .origin(origin_y_r), .scale(scale_r), .grid(gy2)
  );

  // Register mapped word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_in_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_in_ready && a_valid_r) begin
      b_type_r  <= a_type_r;
      b_x1_r    <= gx1;
      b_y1_r    <= gy1;
      b_x2_r    <= gx2;
      b_y2_r    <= gy2;
      b_label_r <= a_label_r;
    end
  end

  // Step the line
  brl_step #(.GRID_BITS(GRID_BITS)) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .b_valid   (b_valid_r),
    .b_type    (b_type_r),
    .b_x1      (b_x1_r),
    .b_y1      (b_y1_r),
    .b_x2      (b_x2_r),
    .b_y2      (b_y2_r),
    .b_label   (b_label_r),
    .b_ready   (b_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (pix),
    .stat      (stat)
  );

  assign out_tdata = {pix.pix_label, pix.pix_y, pix.pix_x};
  assign out_tlast = pix.last_pixel;

  // Checks
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> a_valid_r)
    else $error("accepted input word not captured");

  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && !b_ready |=> b_valid_r)
    else $error("stalled mapped word dropped");

  a_end_line: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(stat.busy) |-> out_tvalid && out_tlast)
    else $error("line ended without a final pixel");

  a_idle_adv: assert property (@(posedge clk) disable iff (!rst_n)
    stat.exec && b_type_r == REQ_ADV && !stat.busy && out_tready |=> !out_tvalid)
    else $error("advance on idle unit produced a pixel");

endmodule

FILE: src/brl_map.sv
// ----------------------------------------------------------------------------
// brl_map: source-to-grid coordinate mapper
// Computes (p - origin) * scale + 1 and saturates to the grid range.
// ----------------------------------------------------------------------------
module brl_map #(
  parameter int GRID_BITS = 12
) (
  input  logic signed [brl_pkg::COORD_W-1:0] coord,
  input  logic signed [brl_pkg::COORD_W-1:0] origin,
  input  logic        [brl_pkg::SCALE_W-1:0] scale,
  output logic        [GRID_BITS-1:0]        grid
);
  import brl_pkg::*;

  localparam logic signed [PROD_W-1:0] GridMax =
    (PROD_W'(1) <<< GRID_BITS) - PROD_W'(1);

  logic signed [COORD_W:0]   diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  g;

  // Offset, scale and bias
  always_comb begin
    diff = $signed({coord[COORD_W-1], coord}) - $signed({origin[COORD_W-1], origin});
    prod = PROD_W'(diff) * $signed({1'b0, scale});
    g    = prod + PROD_W'(1);
  end

  // Clamp to [0, 2^GRID_BITS - 1]
  always_comb begin
    if (g[PROD_W-1]) begin
      grid = '0;
    end else if (g > GridMax) begin
      grid = {GRID_BITS{1'b1}};
    end else begin
      grid = g[GRID_BITS-1:0];
    end
  end

endmodule

FILE: src/brl_step.sv
// ----------------------------------------------------------------------------
// brl_step: Bresenham stepping core with result register
// Loads set up the line state; advances of an active line emit one pixel and step the error.
// ----------------------------------------------------------------------------
module brl_step #(
  parameter int GRID_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          b_valid,
  input  brl_pkg::brl_req_t             b_type,
  input  logic [GRID_BITS-1:0]          b_x1,
  input  logic [GRID_BITS-1:0]          b_y1,
  input  logic [GRID_BITS-1:0]          b_x2,
  input  logic [GRID_BITS-1:0]          b_y2,
  input  logic [brl_pkg::LABEL_W-1:0]   b_label,
  output logic                          b_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output brl_pkg::brl_pix_t             out_pix,
  output brl_pkg::brl_stat_t            stat
);
  import brl_pkg::*;

  localparam int G = GRID_BITS;
  localparam int E = GRID_BITS + 2;

  // Line state
  logic                busy_r;
  logic [G-1:0]        major_pos_r;
  logic [G-1:0]        major_end_r;
  logic [G-1:0]        minor_pos_r;
  logic signed [E-1:0] err_r;
  logic [G:0]          twice_dmajor_r;
  logic [G:0]          twice_dminor_r;
  logic                minor_down_r;
  logic                steep_r;
  logic [LABEL_W-1:0]  label_r;
  logic                out_valid_r;
  brl_pix_t            out_pix_r;

  logic                out_free;
  logic                go;
  logic                go_adv;

  // Load setup
  logic signed [G:0]   dx;
  logic signed [G:0]   dy;
  logic [G:0]          ndx;
  logic [G:0]          ndy;
  logic [G-1:0]        adx;
  logic [G-1:0]        ady;
  logic                steep;
  logic [G-1:0]        a1, a2, c1, c2;
  logic                flip;
  logic [G-1:0]        maj_s, maj_e, min_s, min_e;
  logic [G-1:0]        dmaj, dmin;

  // Advance step
  logic                last;
  logic signed [E-1:0] err_sub;
  logic [G-1:0]        px, py;
  logic [G+PIX_W-1:0]  px_ext, py_ext;

  // Handshake: loads and idle advances never need the result slot
  assign out_free = !out_valid_r || out_ready;
  assign b_ready  = (b_type == REQ_LOAD) || !busy_r || out_free;
  assign go       = b_valid && b_ready;
  assign go_adv   = go && (b_type == REQ_ADV) && busy_r;

  // Classify and order the endpoints
  always_comb begin
    dx    = $signed({1'b0, b_x2}) - $signed({1'b0, b_x1});
    dy    = $signed({1'b0, b_y2}) - $signed({1'b0, b_y1});
    ndx   = -dx;
    ndy   = -dy;
    adx   = dx[G] ? ndx[G-1:0] : dx[G-1:0];
    ady   = dy[G] ? ndy[G-1:0] : dy[G-1:0];
    steep = ady > adx;
    a1    = steep ? b_y1 : b_x1;
    c1    = steep ? b_x1 : b_y1;
    a2    = steep ? b_y2 : b_x2;
    c2    = steep ? b_x2 : b_y2;
    flip  = a1 > a2;
    maj_s = flip ? a2 : a1;
    maj_e = flip ? a1 : a2;
    min_s = flip ? c2 : c1;
    min_e = flip ? c1 : c2;
    dmaj  = steep ? ady : adx;
    dmin  = steep ? adx : ady;
  end

  // Current pixel and error step
  always_comb begin
    last    = major_pos_r >= major_end_r;
    err_sub = err_r - $signed({1'b0, twice_dminor_r});
    px      = steep_r ? minor_pos_r : major_pos_r;
    py      = steep_r ? major_pos_r : minor_pos_r;
    px_ext  = {{PIX_W{1'b0}}, px};
    py_ext  = {{PIX_W{1'b0}}, py};
  end

  // Hold line state, advance on each emitted pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (go && (b_type == REQ_LOAD)) begin
        busy_r <= 1'b1;
      end else if (go_adv) begin
        out_valid_r <= 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Line registers and result word
  always_ff @(posedge clk) begin
    if (go && (b_type == REQ_LOAD)) begin
      steep_r        <= steep;
      major_pos_r    <= maj_s;
      major_end_r    <= maj_e;
      minor_pos_r    <= min_s;
      twice_dmajor_r <= {dmaj, 1'b0};
      twice_dminor_r <= {dmin, 1'b0};
      err_r          <= $signed({2'b00, dmaj});
      minor_down_r   <= !(min_s < min_e);
      label_r        <= b_label;
    end else if (go_adv) begin
      out_pix_r.pix_x      <= px_ext[PIX_W-1:0];
      out_pix_r.pix_y      <= py_ext[PIX_W-1:0];
      out_pix_r.pix_label  <= label_r;
      out_pix_r.last_pixel <= last;
      if (!last) begin
        major_pos_r <= major_pos_r + G'(1);
        if (err_sub[E-1]) begin
          minor_pos_r <= minor_down_r ? (minor_pos_r - G'(1)) : (minor_pos_r + G'(1));
          err_r       <= err_sub + $signed({1'b0, twice_dmajor_r});
        end else begin
          err_r <= err_sub;
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pix       = out_pix_r;
  assign stat.busy     = busy_r;
  assign stat.exec     = go;
  assign stat.exec_adv = go_adv;

endmodule
